[rtl/cba_pkg.sv]
// Shared types and constants for the contiguous bitmap allocator.
// No dependencies; every other file of the block but cba_ram imports this package.
package cba_pkg;

   // Widths of the fixed request, response and register fields.
   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 11;
   localparam int DATA_W   = 32;
   localparam int RUN_W    = 17;
   localparam int START_W  = 16;
   localparam int FDB_W    = 16;

   // Largest supported word is 64 bits, so bit positions fit in six bits.
   localparam int MAX_WORD_LOG = 6;

   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NOP   = 2'd3;

   // What the run finder reports about one bitmap word.
   typedef struct packed {
      logic                    inside_hit;   // a full run lies inside the word
      logic [MAX_WORD_LOG-1:0] inside_end;   // lowest bit that ends such a run
      logic                    all_free;     // no used bit in the word
      logic [MAX_WORD_LOG:0]   bottom_free;  // free bits counted up from bit 0
      logic [MAX_WORD_LOG:0]   top_free;     // free bits counted down from the top bit
   } scan_result_type;

endpackage

[rtl/contiguous_bitmap_allocator.sv]
// Top level of the contiguous bitmap allocator; uses cba_pkg, cba_ram and cba_run_finder.
// The bitmap lives in one RAM of BITMAP_BITS/WORD_BITS words, and after reset the block
// clears it, one word per cycle, so busy stays high until every word is cleared, and
// only then is the first command taken. A write-word command's result follows in the next
// cycle; a read-word command's result is registered after the RAM read and the read state.
// An allocate command scans the bitmap one word per cycle, starting at the word that
// holds first_data_block, and a successful one then rewrites every word of the run in a
// read-modify-write stream of one word per cycle. The RAM's single read port sets the
// one-word-per-cycle pace. Each result beat is shown on the rsp_ ports for one cycle
// under rsp_strobe and cannot be held off. WORD_BITS and BITMAP_BITS must be powers of
// two. The first-data-block register may be written whenever the block is idle.
module contiguous_bitmap_allocator #(
   parameter int BITMAP_BITS = 65536,
   parameter int WORD_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cba_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [cba_pkg::INDEX_W-1:0]   req_word_index,
   input  logic [cba_pkg::DATA_W-1:0]    req_word_data,
   input  logic [cba_pkg::RUN_W-1:0]     req_run_length,
   output logic                          rsp_strobe,
   output logic                          rsp_status,
   output logic [cba_pkg::START_W-1:0]   rsp_start_block,
   output logic [cba_pkg::DATA_W-1:0]    rsp_read_data,
   input  logic                          csr_write_en,
   input  logic [cba_pkg::FDB_W-1:0]     csr_first_data_block
);
   import cba_pkg::*;

   localparam int LOG_W      = $clog2(WORD_BITS);
   localparam int WORD_COUNT = BITMAP_BITS / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BLK_W      = $clog2(BITMAP_BITS);
   localparam int CNT_W      = BLK_W + 1;
   localparam int CMP_W      = ((CNT_W > RUN_W) ? CNT_W : RUN_W) + 1;
   localparam int IDX_EXT_W  = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;
   localparam int DATA_EXT_W = (WORD_BITS > DATA_W) ? WORD_BITS : DATA_W;
   localparam int START_EXT_W = (BLK_W > START_W) ? BLK_W : START_W;
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);
   localparam logic [FDB_W-1:0]  FDB_RESET = 16'd26;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_READ    = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_MARK_RD = 3'd4;
   localparam logic [2:0] ST_MARK    = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [ADDR_W-1:0]    mark_addr_ff, mark_addr_in;
   logic [CNT_W-1:0]     carry_ff, carry_in;
   logic [BLK_W-1:0]     first_blk_ff, first_blk_in;
   logic [BLK_W-1:0]     start_ff, start_in;
   logic [RUN_W-1:0]     need_ff, need_in;
   logic                 first_word_ff, first_word_in;
   logic                 idx_ok_ff, idx_ok_in;
   logic [FDB_W-1:0]     fdb_ff;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [DATA_W-1:0]    rsp_read_ff, rsp_read_in;

   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata, mem_q;

   logic                 accept;
   logic [IDX_EXT_W-1:0] idx_ext;
   logic                 idx_ok;
   logic [ADDR_W-1:0]    idx_addr;
   logic [DATA_EXT_W-1:0] wr_ext, rd_ext;
   logic [CMP_W-1:0]     fdb_ext;
   logic                 fdb_ok;
   logic [ADDR_W-1:0]    fdb_word;
   logic [LOG_W-1:0]     fdb_off;

   logic [WORD_BITS-1:0] scan_word;
   logic                 need_fits;
   scan_result_type      scan;
   logic [CMP_W-1:0]     base_c;
   logic                 carry_hit;
   logic [CMP_W-1:0]     inside_start_c;
   logic [CMP_W-1:0]     next_first_c;

   logic [CMP_W-1:0]     end_c;
   logic [BLK_W-1:0]     end_blk;
   logic [ADDR_W-1:0]    start_word, end_word;
   logic [LOG_W-1:0]     lo_off, hi_off;
   logic [WORD_BITS-1:0] mark_mask;
   logic [START_EXT_W-1:0] start_ext;

   cba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   cba_run_finder #(
      .WORD_BITS (WORD_BITS)
   ) u_finder (
      .word      (scan_word),
      .need_low  (need_ff[LOG_W:0]),
      .need_fits (need_fits),
      .result    (scan)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   assign idx_ext  = IDX_EXT_W'(req_word_index);
   assign idx_ok   = (idx_ext < IDX_EXT_W'(WORD_COUNT));
   assign idx_addr = idx_ext[ADDR_W-1:0];
   assign wr_ext   = DATA_EXT_W'(req_word_data);
   assign rd_ext   = DATA_EXT_W'(mem_q);

   assign fdb_ext  = CMP_W'(fdb_ff);
   assign fdb_ok   = (fdb_ext < CMP_W'(BITMAP_BITS));
   assign fdb_word = ADDR_W'(fdb_ext >> LOG_W);
   assign fdb_off  = fdb_ff[LOG_W-1:0];

   // Blocks below the first data block count as used in the first scanned word.
   assign scan_word = mem_q | (first_word_ff ? ~({WORD_BITS{1'b1}} << fdb_off) : '0);
   assign need_fits = (CMP_W'(need_ff) <= CMP_W'(WORD_BITS));
   assign base_c    = CMP_W'(scan_addr_ff) << LOG_W;

   // A run that started in earlier words completes within this word's free bottom bits.
   assign carry_hit = (carry_ff != '0) &&
                      (CMP_W'(carry_ff) + CMP_W'(scan.bottom_free) >= CMP_W'(need_ff));
   assign inside_start_c = base_c + CMP_W'(scan.inside_end) + CMP_W'(1) - CMP_W'(need_ff);
   assign next_first_c   = base_c + CMP_W'(WORD_BITS) - CMP_W'(scan.top_free);

   assign end_c      = CMP_W'(start_ff) + CMP_W'(need_ff) - CMP_W'(1);
   assign end_blk    = end_c[BLK_W-1:0];
   assign start_word = ADDR_W'(start_ff >> LOG_W);
   assign end_word   = ADDR_W'(end_blk >> LOG_W);
   assign lo_off     = (mark_addr_ff == start_word) ? start_ff[LOG_W-1:0] : '0;
   assign hi_off     = (mark_addr_ff == end_word) ? end_blk[LOG_W-1:0] : LOG_W'(WORD_BITS - 1);
   assign mark_mask  = ({WORD_BITS{1'b1}} << lo_off) &
                       ({WORD_BITS{1'b1}} >> (LOG_W'(WORD_BITS - 1) - hi_off));
   assign start_ext  = START_EXT_W'(start_ff);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      scan_addr_in  = scan_addr_ff;
      mark_addr_in  = mark_addr_ff;
      carry_in      = carry_ff;
      first_blk_in  = first_blk_ff;
      start_in      = start_ff;
      need_in       = need_ff;
      first_word_in = first_word_ff;
      idx_ok_in     = idx_ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = 1'b0;
      rsp_start_in  = '0;
      rsp_read_in   = '0;
      mem_we        = 1'b0;
      mem_waddr     = clr_addr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = scan_addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_WRITE: begin
                     mem_we        = idx_ok;
                     mem_waddr     = idx_addr;
                     mem_wdata     = wr_ext[WORD_BITS-1:0];
                     rsp_strobe_in = 1'b1;
                  end
                  OP_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_addr;
                     idx_ok_in = idx_ok;
                     state_in  = ST_READ;
                  end
                  OP_ALLOC: begin
                     need_in = req_run_length;
                     if ((req_run_length == '0) || !fdb_ok) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = 1'b1;
                     end else begin
                        mem_re        = 1'b1;
                        mem_raddr     = fdb_word;
                        scan_addr_in  = fdb_word;
                        carry_in      = '0;
                        first_word_in = 1'b1;
                        state_in      = ST_SCAN;
                     end
                  end
                  OP_NOP: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_read_in   = idx_ok_ff ? rd_ext[DATA_W-1:0] : '0;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            first_word_in = 1'b0;
            priority if (carry_hit) begin
               start_in = first_blk_ff;
               state_in = ST_MARK_RD;
            end else if (scan.inside_hit) begin
               start_in = inside_start_c[BLK_W-1:0];
               state_in = ST_MARK_RD;
            end else if (scan_addr_ff == LAST_WORD) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               mem_re       = 1'b1;
               mem_raddr    = scan_addr_ff + ADDR_W'(1);
               scan_addr_in = scan_addr_ff + ADDR_W'(1);
               if (scan.all_free) begin
                  carry_in = carry_ff + CNT_W'(WORD_BITS);
                  if (carry_ff == '0) begin
                     first_blk_in = base_c[BLK_W-1:0];
                  end
               end else begin
                  carry_in     = CNT_W'(scan.top_free);
                  first_blk_in = next_first_c[BLK_W-1:0];
               end
            end
         end
         ST_MARK_RD: begin
            mem_re       = 1'b1;
            mem_raddr    = start_word;
            mark_addr_in = start_word;
            state_in     = ST_MARK;
         end
         ST_MARK: begin
            // Write back the current word while the next one is being read.
            mem_we    = 1'b1;
            mem_waddr = mark_addr_ff;
            mem_wdata = mem_q | mark_mask;
            if (mark_addr_ff == end_word) begin
               rsp_strobe_in = 1'b1;
               rsp_start_in  = start_ext[START_W-1:0];
               state_in      = ST_IDLE;
            end else begin
               mem_re       = 1'b1;
               mem_raddr    = mark_addr_ff + ADDR_W'(1);
               mark_addr_in = mark_addr_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
         fdb_ff        <= FDB_RESET;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_en) begin
            fdb_ff <= csr_first_data_block;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      mark_addr_ff  <= mark_addr_in;
      carry_ff      <= carry_in;
      first_blk_ff  <= first_blk_in;
      start_ff      <= start_in;
      need_ff       <= need_in;
      first_word_ff <= first_word_in;
      idx_ok_ff     <= idx_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_read_ff   <= rsp_read_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_block = rsp_start_ff;
   assign rsp_read_data   = rsp_read_ff;

   // No result beat may appear while the bitmap is still being cleared.
   a_no_beat_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_strobe)
      else $error("result beat during bitmap clear");

   // The read-modify-write stream never reads the word it is writing.
   a_rmw_no_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("bitmap read and write hit the same word");

   // A write-word command answers in the very next cycle.
   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_WRITE)) |=> rsp_strobe)
      else $error("write-word command without result beat");

   // The marking pass stays within the words of the allocated run.
   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> ((mark_addr_ff >= start_word) && (mark_addr_ff <= end_word)))
      else $error("marking pass left the allocated run");

endmodule

[rtl/cba_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module cba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/cba_run_finder.sv]
// Per-word analysis for the first-fit scan: free runs inside one bitmap word.
// Depends on cba_pkg for the result struct.
module cba_run_finder #(
   parameter int WORD_BITS = 32,
   localparam int LOG_W = $clog2(WORD_BITS)
) (
   input  logic [WORD_BITS-1:0]   word,
   input  logic [LOG_W:0]         need_low,
   input  logic                   need_fits,
   output cba_pkg::scan_result_type result
);
   import cba_pkg::*;

   // free_run[k][p] is set when the 2**k bits ending at bit p are all free.
   logic [WORD_BITS-1:0] free_run [LOG_W+1];
   logic [WORD_BITS-1:0] window;

   always_comb begin
      free_run[0] = ~word;
      for (int k = 1; k <= LOG_W; k++) begin
         free_run[k] = free_run[k-1] & (free_run[k-1] << (2 ** (k-1)));
      end
   end

   // Chain power-of-two windows along the bits of the request length.
   always_comb begin
      logic [LOG_W+1:0] offset;
      window = '1;
      offset = '0;
      for (int k = 0; k <= LOG_W; k++) begin
         if (need_low[k]) begin
            window = window & (free_run[k] << offset);
            offset = offset + (LOG_W+2)'(2 ** k);
         end
      end
      if (!need_fits) begin
         window = '0;
      end
   end

   always_comb begin
      result.inside_hit  = |window;
      result.inside_end  = '0;
      result.all_free    = ~|word;
      result.bottom_free = (MAX_WORD_LOG+1)'(WORD_BITS);
      result.top_free    = (MAX_WORD_LOG+1)'(WORD_BITS);
      for (int p = WORD_BITS-1; p >= 0; p--) begin
         if (window[p]) begin
            result.inside_end = MAX_WORD_LOG'(p);
         end
         if (word[p]) begin
            result.bottom_free = (MAX_WORD_LOG+1)'(p);
         end
      end
      for (int p = 0; p < WORD_BITS; p++) begin
         if (word[p]) begin
            result.top_free = (MAX_WORD_LOG+1)'(WORD_BITS - 1 - p);
         end
      end
   end

endmodule

[sim/cba_checker.sv]
// Checker for the contiguous bitmap allocator: watches the command, result and
// register ports, predicts each result and compares it field by field.
// Depends on cba_pkg for the field widths and opcodes.
module cba_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [cba_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [cba_pkg::INDEX_W-1:0]   req_word_index,
   input  logic [cba_pkg::DATA_W-1:0]    req_word_data,
   input  logic [cba_pkg::RUN_W-1:0]     req_run_length,
   input  logic                          rsp_strobe,
   input  logic                          rsp_status,
   input  logic [cba_pkg::START_W-1:0]   rsp_start_block,
   input  logic [cba_pkg::DATA_W-1:0]    rsp_read_data,
   input  logic                          csr_write_en,
   input  logic [cba_pkg::FDB_W-1:0]     csr_first_data_block,
   output int                            errors,
   output int                            pending,
   output int                            grants,
   output int                            refusals
);
   timeunit 1ns;
   timeprecision 1ps;
   import cba_pkg::*;

   localparam int WORD_BITS   = 32;
   localparam int WORD_COUNT  = 2048;
   localparam int BLOCK_COUNT = WORD_COUNT * WORD_BITS;

   typedef struct packed {
      logic               status;
      logic [START_W-1:0] start_block;
      logic [DATA_W-1:0]  read_data;
   } reply_type;

   logic [WORD_BITS-1:0] usage_words [WORD_COUNT];
   logic [FDB_W-1:0]     scan_floor;
   reply_type            expected_replies [$];
   reply_type            oldest;
   reply_type            fresh;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   // First-fit search from the scan floor; returns the run start or -1.
   // Whole words that are all used or all free are stepped over in one go.
   function automatic int first_fit(input int unsigned need);
      int unsigned          b;
      int unsigned          run;
      int unsigned          head;
      logic [WORD_BITS-1:0] w;
      if (need == 0) return -1;
      run  = 0;
      head = 0;
      b    = scan_floor;
      while (b < BLOCK_COUNT) begin
         w = usage_words[b / WORD_BITS];
         if (b % WORD_BITS == 0 && w == '1) begin
            run = 0;
            b += WORD_BITS;
         end else if (b % WORD_BITS == 0 && w == '0) begin
            if (run == 0) head = b;
            run += WORD_BITS;
            if (run >= need) return head;
            b += WORD_BITS;
         end else if (!w[b % WORD_BITS]) begin
            if (run == 0) head = b;
            run++;
            if (run == need) return head;
            b++;
         end else begin
            run = 0;
            b++;
         end
      end
      return -1;
   endfunction

   function automatic reply_type bitmap_command_result(
      input logic [OPCODE_W-1:0] opcode,
      input logic [INDEX_W-1:0]  index,
      input logic [DATA_W-1:0]   data,
      input logic [RUN_W-1:0]    length
   );
      reply_type   r;
      int          found;
      int unsigned blk;
      r = '0;
      case (opcode)
         OP_WRITE: usage_words[index] = data;
         OP_READ:  r.read_data = usage_words[index];
         OP_ALLOC: begin
            found = first_fit(length);
            if (found < 0) begin
               r.status = 1'b1;
            end else begin
               for (int unsigned i = 0; i < length; i++) begin
                  blk = found + i;
                  usage_words[blk / WORD_BITS] |= 32'd1 << (blk % WORD_BITS);
               end
               r.start_block = found[START_W-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (usage_words[i]) usage_words[i] = '0;
         scan_floor = 16'd26;
         expected_replies.delete();
         errors   = 0;
         grants   = 0;
         refusals = 0;
      end else begin
         // The result side is checked first, so a beat can never be matched
         // against a command taken at the same edge.
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("result beat with no command waiting");
            end else begin
               oldest = expected_replies.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, oldest.status));
               if (rsp_start_block !== oldest.start_block)
                  report_mismatch($sformatf("start_block got %0d want %0d",
                                            rsp_start_block, oldest.start_block));
               if (rsp_read_data !== oldest.read_data)
                  report_mismatch($sformatf("read_data got %h want %h",
                                            rsp_read_data, oldest.read_data));
            end
         end
         if (start && !busy) begin
            fresh = bitmap_command_result(req_opcode, req_word_index, req_word_data,
                                          req_run_length);
            if (req_opcode == OP_ALLOC) begin
               if (fresh.status) refusals++;
               else grants++;
            end
            expected_replies.push_back(fresh);
         end
         if (csr_write_en) scan_floor = csr_first_data_block;
      end
      pending = expected_replies.size();
   end

endmodule

[sim/contiguous_bitmap_allocator_tb.sv]
// Testbench top for the contiguous bitmap allocator: drives commands and register
// writes, and gives the verdict from the counts of cba_checker.
// Depends on cba_pkg, the allocator RTL and sim/cba_checker.sv.
module contiguous_bitmap_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cba_pkg::*;

   localparam int IDLE_LIMIT  = 20000;
   localparam int PHASE_ITEMS = 45;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [OPCODE_W-1:0] req_opcode = '0;
   logic [INDEX_W-1:0]  req_word_index = '0;
   logic [DATA_W-1:0]   req_word_data = '0;
   logic [RUN_W-1:0]    req_run_length = '0;
   logic                csr_write_en = 1'b0;
   logic [FDB_W-1:0]    csr_first_data_block = '0;

   logic                busy;
   logic                rsp_strobe;
   logic                rsp_status;
   logic [START_W-1:0]  rsp_start_block;
   logic [DATA_W-1:0]   rsp_read_data;

   int errors;
   int pending;
   int grants;
   int refusals;
   int sent_by_op [4];
   int idle_cycles;
   bit steady;

   always #5 clock = ~clock;

   contiguous_bitmap_allocator u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_word_index       (req_word_index),
      .req_word_data        (req_word_data),
      .req_run_length       (req_run_length),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_start_block      (rsp_start_block),
      .rsp_read_data        (rsp_read_data),
      .csr_write_en         (csr_write_en),
      .csr_first_data_block (csr_first_data_block)
   );

   cba_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_word_index       (req_word_index),
      .req_word_data        (req_word_data),
      .req_run_length       (req_run_length),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_start_block      (rsp_start_block),
      .rsp_read_data        (rsp_read_data),
      .csr_write_en         (csr_write_en),
      .csr_first_data_block (csr_first_data_block),
      .errors               (errors),
      .pending              (pending),
      .grants               (grants),
      .refusals             (refusals)
   );

   // Ends the run when neither a command nor a result beat moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Entered and left at a falling edge. Start stays high into the next
   // command unless a random gap drops it.
   task automatic issue_command(
      input logic [OPCODE_W-1:0] op,
      input logic [INDEX_W-1:0]  index,
      input logic [DATA_W-1:0]   data,
      input logic [RUN_W-1:0]    length
   );
      start          = 1'b1;
      req_opcode     = op;
      req_word_index = index;
      req_word_data  = data;
      req_run_length = length;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent_by_op[op]++;
      if (!steady) begin
         while ($urandom_range(0, 99) < 37) begin
            start = 1'b0;
            @(negedge clock);
         end
      end
   endtask

   task automatic set_scan_floor(input logic [FDB_W-1:0] value);
      start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_en         = 1'b1;
      csr_first_data_block = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom & $urandom & $urandom;
         4:       return $urandom;
         default: return ~(32'd1 << $urandom_range(0, 31));
      endcase
   endfunction

   function automatic logic [RUN_W-1:0] random_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return '0;
      else if (pick < 75) return RUN_W'($urandom_range(1, 24));
      else if (pick < 92) return RUN_W'($urandom_range(25, 300));
      else if (pick < 98) return RUN_W'($urandom_range(301, 4000));
      else return 17'd65536;
   endfunction

   // Word traffic mostly lands just above the scan floor, so writes keep
   // reshaping the area that the allocations search.
   task automatic random_phase(input logic [FDB_W-1:0] floor_value, input int count);
      int home;
      int offset;
      int pick;
      logic [INDEX_W-1:0] index;
      set_scan_floor(floor_value);
      home = floor_value / 32;
      repeat (count) begin
         offset = $urandom_range(0, 15);
         if ($urandom_range(0, 99) < 20) index = INDEX_W'($urandom_range(0, 2047));
         else if (home + offset > 2047) index = INDEX_W'(home - offset);
         else index = INDEX_W'(home + offset);
         pick = $urandom_range(0, 99);
         if (pick < 35)
            issue_command(OP_WRITE, index, random_word(), RUN_W'($urandom_range(0, 65536)));
         else if (pick < 55)
            issue_command(OP_READ, index, $urandom, RUN_W'($urandom_range(0, 65536)));
         else if (pick < 95)
            issue_command(OP_ALLOC, INDEX_W'($urandom), $urandom, random_length());
         else
            issue_command(OP_NOP, INDEX_W'($urandom), $urandom,
                          RUN_W'($urandom_range(0, 65536)));
      end
   endtask

   initial begin
      foreach (sent_by_op[i]) sent_by_op[i] = 0;
      steady = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, starting from an empty bitmap and the reset floor.
      issue_command(OP_READ,  11'd0,    '0,           17'd0);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd0);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd1);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd6);
      issue_command(OP_READ,  11'd0,    '0,           17'd0);
      issue_command(OP_WRITE, 11'd2047, '1,           17'd0);
      issue_command(OP_READ,  11'd2047, '0,           17'd0);
      issue_command(OP_WRITE, 11'd1,    32'hAAAAAAAA, 17'd0);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd2);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd1);
      issue_command(OP_WRITE, 11'd0,    '0,           17'd0);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd26);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd65536);
      issue_command(OP_NOP,   11'd2047, '1,           17'd65536);
      issue_command(OP_READ,  11'd1,    '0,           17'd0);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd30000);
      issue_command(OP_READ,  11'd100,  '0,           17'd0);
      issue_command(OP_WRITE, 11'd2047, '0,           17'd0);
      // Highest floor: one block is left to hand out, then nothing fits.
      set_scan_floor(16'd65535);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd1);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd1);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd2);
      set_scan_floor(16'd0);
      issue_command(OP_ALLOC, 11'd0,    '0,           17'd26);

      random_phase(16'd26, PHASE_ITEMS);
      steady = 1'b1;
      random_phase(16'd0, PHASE_ITEMS);
      steady = 1'b0;
      random_phase(16'd65535, PHASE_ITEMS);
      random_phase(16'd65504, PHASE_ITEMS);
      random_phase(16'd1000, PHASE_ITEMS);
      random_phase(FDB_W'($urandom_range(0, 65535)), PHASE_ITEMS);

      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Covered %0d word writes, %0d word reads, %0d allocations, %0d no-ops",
               sent_by_op[OP_WRITE], sent_by_op[OP_READ], sent_by_op[OP_ALLOC],
               sent_by_op[OP_NOP]);
      $display("Allocations granted %0d, refused %0d, across nine scan floor settings",
               grants, refusals);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
